// ===== design/gcl_pkg.sv =====
package gcl_pkg;

    localparam int DEFAULT_COORD_WIDTH = 24;
    localparam int CFG_INDEX_WIDTH     = 3;
    localparam int CFG_DATA_WIDTH      = 24;
    localparam int IN_TDATA_WIDTH      = 56;
    localparam int OUT_TDATA_WIDTH     = 104;

    // Character codes.
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_HASH    = 8'd35;
    localparam logic [7:0] CODE_LOW     = 8'd32;
    localparam logic [7:0] CODE_HIGH    = 8'd127;

    // Reset values of the configuration registers.
    localparam logic [7:0]  LINE_HEIGHT_RESET = 8'd16;
    localparam logic [15:0] SCALE_RESET       = 16'd256;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LEFT_EDGE      = 3'd0,
        REG_RIGHT_EDGE     = 3'd1,
        REG_TOP_LINE_Y     = 3'd2,
        REG_BOTTOM_LIMIT_Y = 3'd3,
        REG_LINE_HEIGHT    = 3'd4,
        REG_X_SCALE        = 3'd5,
        REG_Y_SCALE        = 3'd6,
        REG_RIGHT_TO_LEFT  = 3'd7
    } cfg_index_t;

    // Signed fields are two's complement bit patterns.
    typedef struct packed {
        logic [23:0] left_edge;
        logic [23:0] right_edge;
        logic [23:0] top_line_y;
        logic [23:0] bottom_limit_y;
        logic [7:0]  line_height;
        logic [15:0] x_scale;
        logic [15:0] y_scale;
        logic        right_to_left;
    } cfg_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       glyph_found;
        logic [7:0] glyph_width;
        logic [7:0] glyph_height;
        logic [7:0] glyph_left;
        logic [8:0] glyph_top;
        logic [7:0] glyph_advance;
        logic       last_of_text;
    } item_t;

    typedef struct packed {
        logic        emit;
        logic [23:0] quad_x;
        logic [23:0] quad_y;
        logic [23:0] quad_w;
        logic [23:0] quad_h;
        logic [6:0]  drawn_code;
    } res_t;

endpackage

// ===== design/gcl_glyph_eval.sv =====
module gcl_glyph_eval #(
    parameter int COORD_WIDTH = gcl_pkg::DEFAULT_COORD_WIDTH
) (
    input  gcl_pkg::cfg_t                  cfg,
    input  gcl_pkg::item_t                 item,
    input  logic signed [COORD_WIDTH-1:0]  pen_x,
    input  logic signed [COORD_WIDTH-1:0]  pen_y,
    input  logic                           halted,
    output logic signed [COORD_WIDTH-1:0]  pen_x_next,
    output logic signed [COORD_WIDTH-1:0]  pen_y_next,
    output logic                           halted_next,
    output logic signed [COORD_WIDTH-1:0]  left_sat,
    output logic signed [COORD_WIDTH-1:0]  top_sat,
    output gcl_pkg::res_t                  res
);

    // Working width: wide enough for any pen or register value plus a step.
    localparam int XW = ((COORD_WIDTH > 24) ? COORD_WIDTH : 24) + 3;

    localparam logic signed [XW-1:0] PEN_MAX = {{(XW-COORD_WIDTH+1){1'b0}},
                                                {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [XW-1:0] PEN_MIN = {{(XW-COORD_WIDTH+1){1'b1}},
                                                {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [XW-1:0] OUT_MAX = {{(XW-23){1'b0}}, {23{1'b1}}};
    localparam logic signed [XW-1:0] OUT_MIN = {{(XW-23){1'b1}}, {23{1'b0}}};

    function automatic logic signed [COORD_WIDTH-1:0] sat_pen(logic signed [XW-1:0] v);
        logic signed [COORD_WIDTH-1:0] r;
        if (v > PEN_MAX)
            r = PEN_MAX[COORD_WIDTH-1:0];
        else if (v < PEN_MIN)
            r = PEN_MIN[COORD_WIDTH-1:0];
        else
            r = v[COORD_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic [23:0] sat_out(logic signed [XW-1:0] v);
        logic [23:0] r;
        if (v > OUT_MAX)
            r = OUT_MAX[23:0];
        else if (v < OUT_MIN)
            r = OUT_MIN[23:0];
        else
            r = v[23:0];
        return r;
    endfunction

    logic signed [XW-1:0] pen_x_w, pen_y_w, left_w, right_w, top_w, bottom_w;
    logic signed [XW-1:0] step_y_w, adv_fixed_w, wrap_x_w, brk_y_w;
    logic signed [XW-1:0] base_x_w, base_y_w, adv_scaled_w, moved_x_w;
    logic signed [XW-1:0] bear_x_w, drop_y_w;
    logic signed [9:0]    drop_px;
    logic signed [COORD_WIDTH-1:0] brk_y;
    logic [23:0] adv_scaled;
    logic        brk_halt, is_newline, has_glyph, wrap, has_pixels, bad_code;

    always_comb
    begin
        pen_x_w     = {{(XW-COORD_WIDTH){pen_x[COORD_WIDTH-1]}}, pen_x};
        pen_y_w     = {{(XW-COORD_WIDTH){pen_y[COORD_WIDTH-1]}}, pen_y};
        left_w      = {{(XW-24){cfg.left_edge[23]}}, cfg.left_edge};
        right_w     = {{(XW-24){cfg.right_edge[23]}}, cfg.right_edge};
        top_w       = {{(XW-24){cfg.top_line_y[23]}}, cfg.top_line_y};
        bottom_w    = {{(XW-24){cfg.bottom_limit_y[23]}}, cfg.bottom_limit_y};
        left_sat    = sat_pen(left_w);
        top_sat     = sat_pen(top_w);

        // Line break: step down one line, stop if below the bottom limit.
        step_y_w    = {{(XW-16){1'b0}}, cfg.line_height, 8'h00};
        brk_y       = sat_pen(pen_y_w - step_y_w);
        brk_y_w     = {{(XW-COORD_WIDTH){brk_y[COORD_WIDTH-1]}}, brk_y};
        brk_halt    = brk_y_w < bottom_w;

        is_newline  = item.char_code == gcl_pkg::CODE_NEWLINE;
        has_glyph   = item.glyph_found && (item.glyph_advance != 8'd0);
        adv_fixed_w = {{(XW-16){1'b0}}, item.glyph_advance, 8'h00};
        wrap_x_w    = pen_x_w + adv_fixed_w;
        wrap        = wrap_x_w > right_w;
        has_pixels  = (item.glyph_width != 8'd0) && (item.glyph_height != 8'd0);

        base_x_w    = wrap ? {{(XW-COORD_WIDTH){left_sat[COORD_WIDTH-1]}}, left_sat}
                           : pen_x_w;
        base_y_w    = wrap ? brk_y_w : pen_y_w;

        adv_scaled   = 24'(item.glyph_advance * cfg.x_scale);
        adv_scaled_w = {{(XW-24){1'b0}}, adv_scaled};
        moved_x_w    = cfg.right_to_left ? base_x_w - adv_scaled_w
                                         : base_x_w + adv_scaled_w;

        bear_x_w    = {{(XW-16){item.glyph_left[7]}}, item.glyph_left, 8'h00};
        drop_px     = $signed({2'b00, item.glyph_height})
                    - $signed({item.glyph_top[8], item.glyph_top});
        drop_y_w    = {{(XW-18){drop_px[9]}}, drop_px, 8'h00};

        bad_code    = (item.char_code < gcl_pkg::CODE_LOW)
                   || (item.char_code > gcl_pkg::CODE_HIGH);

        res.quad_x     = sat_out(base_x_w + bear_x_w);
        res.quad_y     = sat_out(base_y_w - drop_y_w);
        res.quad_w     = 24'(item.glyph_width * cfg.x_scale);
        res.quad_h     = 24'(item.glyph_height * cfg.y_scale);
        res.drawn_code = bad_code ? gcl_pkg::CODE_HASH[6:0] : item.char_code[6:0];
        res.emit       = 1'b0;

        pen_x_next  = pen_x;
        pen_y_next  = pen_y;
        halted_next = halted;

        if (!halted)
        begin
            if (is_newline)
            begin
                pen_y_next = brk_y;
                if (brk_halt)
                    halted_next = 1'b1;
                else
                    pen_x_next = left_sat;
            end
            else if (has_glyph)
            begin
                if (wrap && brk_halt)
                begin
                    pen_y_next  = brk_y;
                    halted_next = 1'b1;
                end
                else
                begin
                    res.emit   = has_pixels;
                    pen_x_next = sat_pen(moved_x_w);
                    pen_y_next = base_y_w[COORD_WIDTH-1:0];
                end
            end
        end

        // The end of a string always puts the pen back at the start.
        if (item.last_of_text)
        begin
            pen_x_next  = left_sat;
            pen_y_next  = top_sat;
            halted_next = 1'b0;
        end
    end

endmodule

// ===== design/glyph_cursor_layout_wrap.sv =====
// Text layout with line wrap: one character per transfer in, one glyph quad out.
//
// The input stream (s_axis_*) carries a character byte and the metrics of its
// glyph, already looked up; tlast marks the final character of a string. The
// output stream (m_axis_*) carries one scaled quad for each found glyph with
// pixels and a nonzero advance, unless it wraps below the bottom limit or
// arrives while layout is stopped; no other character produces a transfer.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register per
// cycle and must be used only while the block is idle; the block itself does
// not enforce it. Writing left_edge or top_line_y sets a reload flag, and the
// pen reloads from the new value unless a character moves on while it is set.
// An input transfer waits in the input register, then passes through the pen
// logic (wrap compare, line step and scaled advance) into the output register.
// The block takes one character per cycle while the output is not stalled.
// When the receiver stalls with a quad waiting, items without output still
// pass; the next item with output waits in the input register and tready
// drops until the quad is taken.
// Reset clears both registers' valid flags, restores the register defaults and
// puts the pen at the origin with layout running.
module glyph_cursor_layout_wrap #(
    parameter int COORD_WIDTH = gcl_pkg::DEFAULT_COORD_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write port.
    input  logic                                   cfg_we,
    input  logic [gcl_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [gcl_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    // Input stream.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, from bit 0: char_code[7:0], glyph_found[8], glyph_width[16:9],
    // glyph_height[24:17], glyph_left[32:25], glyph_top[41:33],
    // glyph_advance[49:42], zero fill[55:50].
    input  logic [gcl_pkg::IN_TDATA_WIDTH-1:0]     s_axis_tdata,
    input  logic                                   s_axis_tlast,
    // Output stream.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata, from bit 0: quad_x[23:0], quad_y[47:24], quad_w[71:48],
    // quad_h[95:72], drawn_code[102:96], zero fill[103].
    output logic [gcl_pkg::OUT_TDATA_WIDTH-1:0]    m_axis_tdata
);

    gcl_pkg::cfg_t  cfg_reg;
    gcl_pkg::item_t in_item_reg;
    gcl_pkg::item_t in_item;
    gcl_pkg::res_t  res;

    logic in_valid_reg;
    logic out_valid_reg;
    logic [gcl_pkg::OUT_TDATA_WIDTH-1:0] out_data_reg;

    logic signed [COORD_WIDTH-1:0] pen_x_reg, pen_y_reg;
    logic signed [COORD_WIDTH-1:0] pen_x_next, pen_y_next;
    logic signed [COORD_WIDTH-1:0] left_sat, top_sat;
    logic halted_reg, halted_next;
    logic reload_x_reg, reload_y_reg;

    logic in_xfer, fire;

    // The character in the input register moves on when its quad, if any,
    // has room in the output register.
    assign fire          = in_valid_reg && (!res.emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        in_item.char_code     = s_axis_tdata[7:0];
        in_item.glyph_found   = s_axis_tdata[8];
        in_item.glyph_width   = s_axis_tdata[16:9];
        in_item.glyph_height  = s_axis_tdata[24:17];
        in_item.glyph_left    = s_axis_tdata[32:25];
        in_item.glyph_top     = s_axis_tdata[41:33];
        in_item.glyph_advance = s_axis_tdata[49:42];
        in_item.last_of_text  = s_axis_tlast;
    end

    gcl_glyph_eval #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_eval (
        .cfg         (cfg_reg),
        .item        (in_item_reg),
        .pen_x       (pen_x_reg),
        .pen_y       (pen_y_reg),
        .halted      (halted_reg),
        .pen_x_next  (pen_x_next),
        .pen_y_next  (pen_y_next),
        .halted_next (halted_next),
        .left_sat    (left_sat),
        .top_sat     (top_sat),
        .res         (res)
    );

    // Control state, configuration and the pen cursor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            pen_x_reg              <= '0;
            pen_y_reg              <= '0;
            halted_reg             <= 1'b0;
            reload_x_reg           <= 1'b0;
            reload_y_reg           <= 1'b0;
            cfg_reg.left_edge      <= '0;
            cfg_reg.right_edge     <= '0;
            cfg_reg.top_line_y     <= '0;
            cfg_reg.bottom_limit_y <= '0;
            cfg_reg.line_height    <= gcl_pkg::LINE_HEIGHT_RESET;
            cfg_reg.x_scale        <= gcl_pkg::SCALE_RESET;
            cfg_reg.y_scale        <= gcl_pkg::SCALE_RESET;
            cfg_reg.right_to_left  <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            if (fire && res.emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            // A cursor register write sets a reload flag; while it is set, the pen reloads
            // from the new value in the configuration register unless a character fires.
            reload_x_reg <= cfg_we && (cfg_index == gcl_pkg::REG_LEFT_EDGE);
            reload_y_reg <= cfg_we && (cfg_index == gcl_pkg::REG_TOP_LINE_Y);

            if (fire)
            begin
                pen_x_reg  <= pen_x_next;
                pen_y_reg  <= pen_y_next;
                halted_reg <= halted_next;
            end
            else
            begin
                if (reload_x_reg)
                    pen_x_reg <= left_sat;
                if (reload_y_reg)
                    pen_y_reg <= top_sat;
            end

            if (cfg_we)
            begin
                unique case (gcl_pkg::cfg_index_t'(cfg_index))
                    gcl_pkg::REG_LEFT_EDGE:      cfg_reg.left_edge      <= cfg_data;
                    gcl_pkg::REG_RIGHT_EDGE:     cfg_reg.right_edge     <= cfg_data;
                    gcl_pkg::REG_TOP_LINE_Y:     cfg_reg.top_line_y     <= cfg_data;
                    gcl_pkg::REG_BOTTOM_LIMIT_Y: cfg_reg.bottom_limit_y <= cfg_data;
                    gcl_pkg::REG_LINE_HEIGHT:    cfg_reg.line_height    <= cfg_data[7:0];
                    gcl_pkg::REG_X_SCALE:        cfg_reg.x_scale        <= cfg_data[15:0];
                    gcl_pkg::REG_Y_SCALE:        cfg_reg.y_scale        <= cfg_data[15:0];
                    gcl_pkg::REG_RIGHT_TO_LEFT:  cfg_reg.right_to_left  <= cfg_data[0];
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            in_item_reg <= in_item;
        if (fire && res.emit)
            out_data_reg <= {1'b0, res.drawn_code, res.quad_h, res.quad_w,
                             res.quad_y, res.quad_x};
    end

endmodule
